/* design/cdq_pkg.sv */
// Shared constants, codes and types for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned CMD_W     = 3;
   localparam int unsigned CAP_W     = 5;
   localparam int unsigned ST_W      = 2;
   localparam int unsigned DEPTH_DEF = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam int unsigned REQ_TDATA_W = 40;
   localparam int unsigned RSP_TDATA_W = 40;
   localparam int unsigned RSP_PAD_W   = RSP_TDATA_W - DATA_W - ST_W - 2;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
   localparam logic [CMD_W-1:0] CMD_PEEK_REAR  = 3'd5;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic              en;
      logic [DATA_W-1:0] data;
   } ring_wr_type;

endpackage

/* design/cdq_cell.sv */
// One storage cell of the rotating slot ring.
`timescale 1ns / 1ps

module cdq_cell import cdq_pkg::*; #(
   parameter int unsigned WIDTH = DATA_W
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] nbr_i,
   input  logic             ld,
   input  logic [WIDTH-1:0] ld_data,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] word_ff;
   logic [WIDTH-1:0] word_in;

   // take the neighbor's word, or the new word when loading
   assign word_in = ld ? ld_data : nbr_i;

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign q = word_ff;

endmodule

/* design/cdq_ring.sv */
// Ring of cells that rotates every cycle; cell 0 shows the slot named by the phase.
`timescale 1ns / 1ps

module cdq_ring import cdq_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEF,
   parameter int unsigned WIDTH = DATA_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ring_wr_type              wr,
   output logic [$clog2(DEPTH)-1:0] phase,
   output logic [WIDTH-1:0]         head_q
);

   localparam int unsigned IW = $clog2(DEPTH);

   logic [WIDTH-1:0] cq [DEPTH];
   logic [IW-1:0]    ph_ff;
   logic [IW-1:0]    ph_in;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         if (i == DEPTH - 1) begin : g_last
            // slot at cell 0 moves here; replace it on a write
            cdq_cell #(.WIDTH(WIDTH)) u_cell (
               .clock   (clock),
               .nbr_i   (cq[0]),
               .ld      (wr.en),
               .ld_data (WIDTH'(wr.data)),
               .q       (cq[i])
            );
         end else begin : g_mid
            cdq_cell #(.WIDTH(WIDTH)) u_cell (
               .clock   (clock),
               .nbr_i   (cq[i+1]),
               .ld      (1'b0),
               .ld_data (cq[i+1]),
               .q       (cq[i])
            );
         end
      end
   endgenerate

   assign ph_in = (ph_ff == IW'(DEPTH - 1)) ? '0 : ph_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= '0;
      end else begin
         ph_ff <= ph_in;
      end
   end

   assign phase  = ph_ff;
   assign head_q = cq[0];

endmodule

/* design/circular_deque.sv */
// Circular deque top level: command decode, ring indices and result register.
// Pops, overflow, underflow, unused commands: result in the cycle after the transfer.
// Push and peek: the request waits in S_SLOT until the target slot rotates into cell 0
// of the ring, then the result is registered; one item is in work at a time.
// Reset (synchronous, active high): indices zero, deque empty, capacity 16.
// Slot contents are undefined after reset; there is no clearing pass.
`timescale 1ns / 1ps

module circular_deque import cdq_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [2:0] command, [34:3] data_value, [39:35] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] read_value, [33:32] status, [34] is_empty, [35] is_full, [39:36] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [CAP_W-1:0]       csr_wr_data
);

   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned CW = (CAP_W > IW + 1) ? CAP_W : IW + 1;

   typedef enum logic {S_IDLE, S_SLOT} state_type;

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] cap);
      logic [CW-1:0] nx;
      nx = CW'(idx) + CW'(1);
      return (nx >= cap) ? '0 : nx[IW-1:0];
   endfunction

   function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] cap);
      logic [CW-1:0] cm1;
      cm1 = cap - CW'(1);
      if (idx == '0 || CW'(idx) > cap) begin
         return cm1[IW-1:0];
      end
      return idx - 1'b1;
   endfunction

   state_type         state_ff, state_in;
   logic [IW-1:0]     head_ff, head_in;
   logic [IW-1:0]     tail_ff, tail_in;
   logic              empty_ff, empty_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [IW-1:0]     tgt_ff, tgt_in;
   logic              pend_wr_ff, pend_wr_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rv_ff, rv_in;
   logic [ST_W-1:0]   st_ff, st_in;
   logic              emp_o_ff, emp_o_in;
   logic              full_o_ff, full_o_in;

   logic [CW-1:0]     cap_eff;
   logic [CMD_W-1:0]  cmd;
   logic [DATA_W-1:0] val;
   logic              accept;
   logic              full_now;

   logic [IW-1:0]     s_head, s_tail, s_tgt;
   logic              s_empty, s_full, s_wr, s_rd;
   logic [ST_W-1:0]   s_st;
   logic [DATA_W-1:0] s_rv;

   ring_wr_type       ring_wr;
   logic [IW-1:0]     ph;
   logic [DATA_W-1:0] ring_q;
   logic              at_tgt;

   assign cmd    = req_tdata[CMD_W-1:0];
   assign val    = req_tdata[CMD_W +: DATA_W];
   assign accept = req_tvalid && req_tready;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CW'(1);
      end else if (CW'(cap_ff) > CW'(DEPTH)) begin
         cap_eff = CW'(DEPTH);
      end else begin
         cap_eff = CW'(cap_ff);
      end
   end

   assign full_now = !empty_ff && (wrap_inc(tail_ff, cap_eff) == head_ff);

   // decode one command against the current indices
   always_comb begin
      s_head  = head_ff;
      s_tail  = tail_ff;
      s_empty = empty_ff;
      s_st    = ST_OK;
      s_rv    = '0;
      s_wr    = 1'b0;
      s_rd    = 1'b0;
      s_tgt   = head_ff;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (full_now) begin
               s_st = ST_OVERFLOW;
            end else if (empty_ff) begin
               s_head  = '0;
               s_tail  = '0;
               s_empty = 1'b0;
               s_wr    = 1'b1;
               s_tgt   = '0;
            end else if (cmd == CMD_PUSH_FRONT) begin
               s_head = wrap_dec(head_ff, cap_eff);
               s_wr   = 1'b1;
               s_tgt  = s_head;
            end else begin
               s_tail = wrap_inc(tail_ff, cap_eff);
               s_wr   = 1'b1;
               s_tgt  = s_tail;
            end
         end
         CMD_POP_FRONT, CMD_POP_REAR: begin
            if (empty_ff) begin
               s_st = ST_UNDERFLOW;
            end else if (head_ff == tail_ff) begin
               s_empty = 1'b1;
               s_head  = '0;
               s_tail  = '0;
            end else if (cmd == CMD_POP_FRONT) begin
               s_head = wrap_inc(head_ff, cap_eff);
            end else begin
               s_tail = wrap_dec(tail_ff, cap_eff);
            end
         end
         CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
            if (empty_ff) begin
               s_st = ST_UNDERFLOW;
               s_rv = '1;
            end else begin
               s_rd  = 1'b1;
               s_tgt = (cmd == CMD_PEEK_FRONT) ? head_ff : tail_ff;
            end
         end
         default: begin
         end
      endcase
      s_full = !s_empty && (wrap_inc(s_tail, cap_eff) == s_head);
   end

   assign at_tgt       = (ph == tgt_ff);
   assign ring_wr.en   = (state_ff == S_SLOT) && pend_wr_ff && at_tgt;
   assign ring_wr.data = wdata_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      empty_in     = empty_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      tgt_in       = tgt_ff;
      pend_wr_in   = pend_wr_ff;
      wdata_in     = wdata_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rv_in        = rv_ff;
      st_in        = st_ff;
      emp_o_in     = emp_o_ff;
      full_o_in    = full_o_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               head_in   = s_head;
               tail_in   = s_tail;
               empty_in  = s_empty;
               rv_in     = s_rv;
               st_in     = s_st;
               emp_o_in  = s_empty;
               full_o_in = s_full;
               if (s_wr || s_rd) begin
                  // wait for the slot to come around
                  state_in   = S_SLOT;
                  tgt_in     = s_tgt;
                  pend_wr_in = s_wr;
                  wdata_in   = val;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_SLOT: begin
            if (at_tgt) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (!pend_wr_ff) begin
                  rv_in = ring_q;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tgt_ff     <= tgt_in;
      pend_wr_ff <= pend_wr_in;
      wdata_ff   <= wdata_in;
      rv_ff      <= rv_in;
      st_ff      <= st_in;
      emp_o_ff   <= emp_o_in;
      full_o_ff  <= full_o_in;
   end

   cdq_ring #(
      .DEPTH (DEPTH),
      .WIDTH (DATA_W)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .wr     (ring_wr),
      .phase  (ph),
      .head_q (ring_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, full_o_ff, emp_o_ff, st_ff, rv_ff};

endmodule

/* design/cdq_check.sv */
// Port-level assertions for the circular deque, bound to the top level.
`timescale 1ns / 1ps

module cdq_check import cdq_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [ST_W-1:0] st;
   logic            emp;
   logic            full;

   assign st   = rsp_tdata[DATA_W +: ST_W];
   assign emp  = rsp_tdata[DATA_W + ST_W];
   assign full = rsp_tdata[DATA_W + ST_W + 1];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(emp && full) && st != 2'd3)
      else $error("empty and full together or bad status");

   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == ST_OVERFLOW |-> full && !emp)
      else $error("overflow reported while not full");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == ST_UNDERFLOW |-> emp)
      else $error("underflow reported while not empty");

endmodule

bind circular_deque cdq_check u_cdq_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* verif/tb_top.sv */
// Self-checking testbench for circular_deque: directed table, random command mix, predictor.
`timescale 1ns / 1ps

module tb_top;
   import cdq_pkg::*;

   localparam int unsigned RING_DEPTH  = DEPTH_DEF;
   localparam int unsigned IDX_W       = $clog2(RING_DEPTH);
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned PHASES      = 12;
   localparam int unsigned PHASE_ITEMS = 148;

   localparam logic [CMD_W-1:0]  CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0]  CMD_SPARE_7 = 3'd7;
   localparam logic [DATA_W-1:0] EMPTY_PEEK  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic [ST_W-1:0]   status;
      logic              is_empty;
      logic              is_full;
   } deque_result_type;

   typedef struct packed {
      logic              is_cap;
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] value;
      logic              typed;
      deque_result_type  want;
   } step_type;

   localparam deque_result_type FROM_MODEL   = '0;
   localparam deque_result_type EMPTY_POP    = '{32'h0, ST_UNDERFLOW, 1'b1, 1'b0};
   localparam deque_result_type EMPTY_LOOK   = '{EMPTY_PEEK, ST_UNDERFLOW, 1'b1, 1'b0};
   localparam deque_result_type EMPTY_NOP    = '{32'h0, ST_OK, 1'b1, 1'b0};
   localparam deque_result_type SINGLE_OVER  = '{32'h0, ST_OVERFLOW, 1'b0, 1'b1};

   // Directed table: empty-deque errors, spare codes, extreme values, overflow at capacity 1,
   // last-element pops, and a capacity above the storage depth.
   step_type plan [0:27] = '{
      '{1'b0, CMD_POP_FRONT,  32'h0000_0000, 1'b1, EMPTY_POP},
      '{1'b0, CMD_POP_REAR,   32'hFFFF_FFFF, 1'b1, EMPTY_POP},
      '{1'b0, CMD_PEEK_FRONT, 32'h0000_0000, 1'b1, EMPTY_LOOK},
      '{1'b0, CMD_PEEK_REAR,  32'h0000_0000, 1'b1, EMPTY_LOOK},
      '{1'b0, CMD_SPARE_6,    32'h1234_5678, 1'b1, EMPTY_NOP},
      '{1'b0, CMD_SPARE_7,    32'hFFFF_FFFF, 1'b1, EMPTY_NOP},
      '{1'b0, CMD_PUSH_REAR,  32'h7FFF_FFFF, 1'b0, FROM_MODEL},
      '{1'b0, CMD_PUSH_FRONT, 32'h8000_0000, 1'b0, FROM_MODEL},
      '{1'b0, CMD_PUSH_REAR,  32'hFFFF_FFFF, 1'b0, FROM_MODEL},
      '{1'b0, CMD_PUSH_FRONT, 32'h0000_0000, 1'b0, FROM_MODEL},
      '{1'b0, CMD_PEEK_FRONT, 32'h0000_0000, 1'b0, FROM_MODEL},
      '{1'b0, CMD_PEEK_REAR,  32'h0000_0000, 1'b0, FROM_MODEL},
      '{1'b0, CMD_POP_FRONT,  32'h0000_0000, 1'b0, FROM_MODEL},
      '{1'b0, CMD_POP_REAR,   32'h0000_0000, 1'b0, FROM_MODEL},
      '{1'b0, CMD_PEEK_FRONT, 32'h0000_0000, 1'b0, FROM_MODEL},
      '{1'b0, CMD_POP_FRONT,  32'h0000_0000, 1'b0, FROM_MODEL},
      '{1'b0, CMD_POP_REAR,   32'h0000_0000, 1'b0, FROM_MODEL},
      '{1'b1, CMD_PUSH_FRONT, 32'd1,         1'b0, FROM_MODEL},
      '{1'b0, CMD_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, FROM_MODEL},
      '{1'b0, CMD_PUSH_REAR,  32'h0000_0001, 1'b1, SINGLE_OVER},
      '{1'b0, CMD_PUSH_FRONT, 32'h5A5A_5A5A, 1'b1, SINGLE_OVER},
      '{1'b0, CMD_PEEK_REAR,  32'h0000_0000, 1'b0, FROM_MODEL},
      '{1'b0, CMD_POP_REAR,   32'h0000_0000, 1'b0, FROM_MODEL},
      '{1'b1, CMD_PUSH_FRONT, 32'd31,        1'b0, FROM_MODEL},
      '{1'b0, CMD_PUSH_REAR,  32'hC3C3_3C3C, 1'b0, FROM_MODEL},
      '{1'b0, CMD_PUSH_FRONT, 32'h0F0F_F0F0, 1'b0, FROM_MODEL},
      '{1'b0, CMD_PEEK_FRONT, 32'h0000_0000, 1'b0, FROM_MODEL},
      '{1'b0, CMD_POP_FRONT,  32'h0000_0000, 1'b0, FROM_MODEL}
   };

   logic [CAP_W-1:0] phase_caps [0:PHASES-1] = '{
      5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd5, 5'd16, 5'd3, 5'd17, 5'd8, 5'd10, 5'd16
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // [2:0] command, [34:3] data_value, [39:35] zero
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [31:0] read_value, [33:32] status, [34] is_empty, [35] is_full, [39:36] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en;
   logic [CAP_W-1:0]       csr_wr_data;

   // predicted deque state
   logic [DATA_W-1:0] ring_mem [RING_DEPTH];
   bit                ring_written [RING_DEPTH];
   logic [IDX_W-1:0]  head_ptr;
   logic [IDX_W-1:0]  tail_ptr;
   logic              ring_empty;
   logic [CAP_W-1:0]  cap_setting;

   deque_result_type awaited_results [$];
   int unsigned      fail_count;
   int unsigned      result_count;
   int unsigned      cycle_count;
   int               stall_left;
   bit               req_idle_on;
   bit               rsp_idle_on;

   circular_deque i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [CAP_W-1:0] cap_used();
      if (cap_setting == '0) return 5'd1;
      if (cap_setting > RING_DEPTH) return CAP_W'(RING_DEPTH);
      return cap_setting;
   endfunction

   function automatic logic [IDX_W-1:0] ring_next(logic [IDX_W-1:0] idx);
      logic [CAP_W-1:0] c;
      c = cap_used();
      return (CAP_W'(idx) + 5'd1 >= c) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(logic [IDX_W-1:0] idx);
      logic [CAP_W-1:0] c;
      c = cap_used();
      if (idx == '0 || CAP_W'(idx) > c) return IDX_W'(c - 5'd1);
      return idx - 1'b1;
   endfunction

   function automatic logic ring_full();
      return !ring_empty && ring_next(tail_ptr) == head_ptr;
   endfunction

   function automatic deque_result_type apply_command(logic [CMD_W-1:0] cmd,
                                                      logic [DATA_W-1:0] value);
      deque_result_type r;
      r = '0;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (ring_full()) begin
               r.status = ST_OVERFLOW;
            end else if (ring_empty) begin
               head_ptr = '0;
               tail_ptr = '0;
               ring_empty = 1'b0;
               ring_mem[0] = value;
               ring_written[0] = 1'b1;
            end else if (cmd == CMD_PUSH_FRONT) begin
               head_ptr = ring_prev(head_ptr);
               ring_mem[head_ptr] = value;
               ring_written[head_ptr] = 1'b1;
            end else begin
               tail_ptr = ring_next(tail_ptr);
               ring_mem[tail_ptr] = value;
               ring_written[tail_ptr] = 1'b1;
            end
         end
         CMD_POP_FRONT, CMD_POP_REAR: begin
            if (ring_empty) begin
               r.status = ST_UNDERFLOW;
            end else if (head_ptr == tail_ptr) begin
               // last element out: both indices return home
               ring_empty = 1'b1;
               head_ptr = '0;
               tail_ptr = '0;
            end else if (cmd == CMD_POP_FRONT) begin
               head_ptr = ring_next(head_ptr);
            end else begin
               tail_ptr = ring_prev(tail_ptr);
            end
         end
         CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
            if (ring_empty) begin
               r.status = ST_UNDERFLOW;
               r.read_value = EMPTY_PEEK;
            end else begin
               r.read_value = ring_mem[cmd == CMD_PEEK_FRONT ? head_ptr : tail_ptr];
            end
         end
         default: begin
         end
      endcase
      r.is_empty = ring_empty;
      r.is_full = ring_full();
      return r;
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   // Hold the item until the transfer, then predict its result.
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value, logic typed,
                            deque_result_type want);
      deque_result_type predicted;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_TDATA_W - DATA_W - CMD_W){1'b0}}, value, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_command(cmd, value);
      awaited_results.push_back(typed ? want : predicted);
   endtask

   task automatic pause_req();
      repeat ($urandom_range(1, 3)) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (RING_DEPTH + 2) @(posedge clock);
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] cap);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      cap_setting = cap;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Receiver stalls come in bursts of random length.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      deque_result_type got;
      deque_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_value = rsp_tdata[DATA_W-1:0];
         got.status = rsp_tdata[DATA_W +: ST_W];
         got.is_empty = rsp_tdata[DATA_W + ST_W];
         got.is_full = rsp_tdata[DATA_W + ST_W + 1];
         if (awaited_results.size() == 0) begin
            note_failure($sformatf("result %0d arrived with nothing expected: rv=%h st=%0d",
                                   result_count, got.read_value, got.status));
         end else begin
            want = awaited_results.pop_front();
            if (got.read_value !== want.read_value || got.status !== want.status ||
                got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
               note_failure({$sformatf("result %0d: expected rv=%h st=%0d empty=%0b full=%0b, ",
                                       result_count, want.read_value, want.status,
                                       want.is_empty, want.is_full),
                             $sformatf("got rv=%h st=%0d empty=%0b full=%0b",
                                       got.read_value, got.status, got.is_empty,
                                       got.is_full)});
            end
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("circular_deque test failed");
         $finish;
      end
   end

   initial begin
      int                r;
      int                phase;
      int                k;
      bit                filling;
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] value;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      fail_count = 0;
      result_count = 0;
      cycle_count = 0;
      stall_left = 0;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      filling = 1'b1;
      head_ptr = '0;
      tail_ptr = '0;
      ring_empty = 1'b1;
      cap_setting = CAP_RESET;
      for (k = 0; k < RING_DEPTH; k++) begin
         ring_mem[k] = '0;
         ring_written[k] = 1'b0;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[n]) begin
         if (plan[n].is_cap) begin
            drain_results();
            set_capacity(plan[n].value[CAP_W-1:0]);
         end else begin
            send_item(plan[n].cmd, plan[n].value, plan[n].typed, plan[n].want);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         // each capacity change waits for every outstanding result
         drain_results();
         set_capacity(phase == 10 ? CAP_W'($urandom_range(0, 31)) : phase_caps[phase]);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 37 == 0) begin
               req_idle_on = (phase != PHASES - 1) && $urandom_range(0, 2) != 0;
               rsp_idle_on = (phase != PHASES - 1) && $urandom_range(0, 2) != 0;
            end
            if (ring_empty) filling = 1'b1;
            else if (ring_full()) filling = 1'b0;
            else if ($urandom_range(0, 19) == 0) filling = ~filling;
            r = $urandom_range(0, 99);
            if (r < 3) begin
               cmd = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
            end else if (r < 23) begin
               cmd = $urandom_range(0, 1) ? CMD_PEEK_REAR : CMD_PEEK_FRONT;
            end else if (r < (filling ? 80 : 40)) begin
               cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
            end else begin
               cmd = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
            end
            // steer away from peeking a slot that was never stored
            if ((cmd == CMD_PEEK_FRONT || cmd == CMD_PEEK_REAR) && !ring_empty &&
                !ring_written[cmd == CMD_PEEK_FRONT ? head_ptr : tail_ptr])
               cmd = CMD_PUSH_REAR;
            case ($urandom_range(0, 7))
               0: value = 32'h8000_0000;
               1: value = 32'h7FFF_FFFF;
               2: value = 32'hFFFF_FFFF;
               3: value = 32'h0000_0000;
               default: value = $urandom;
            endcase
            send_item(cmd, value, 1'b0, FROM_MODEL);
            if (req_idle_on && $urandom_range(0, 3) == 0) pause_req();
         end
      end

      drain_results();
      if (awaited_results.size() != 0)
         note_failure($sformatf("%0d results never arrived", awaited_results.size()));
      if (fail_count == 0) begin
         $display("circular_deque test passed");
      end else begin
         $display("circular_deque test failed");
      end
      $finish;
   end

endmodule

/* circular_deque.f */
design/cdq_pkg.sv
design/cdq_cell.sv
design/cdq_ring.sv
design/circular_deque.sv
design/cdq_check.sv
verif/tb_top.sv
